>>> rtl/core/ple_pkg.sv
// Package for the positional list engine: operation and status codes,
// request and result item types, and the free-stack control group.
// No dependencies.
package ple_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DISPLAY   = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] element;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } rsp_t;

    typedef struct packed {
        logic rd;
        logic push;
        logic clear;
    } fs_ctl_t;

endpackage

>>> rtl/core/ple_stream_if.sv
// Valid/ready channel carrying one item per handshake.
// Payload type is set per instance; used with ple_pkg item types.
interface ple_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ple_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ple_free_stack.sv
// Free-slot stack: RAM plus per-entry written bits; an unwritten entry
// reads as its own index, so reset and clear need no sweep.
// Depends on ple_pkg and ple_ram.
module ple_free_stack #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ple_pkg::fs_ctl_t            ctl,
    input  logic [$clog2(CAPACITY)-1:0] raddr,
    input  logic [$clog2(CAPACITY)-1:0] waddr,
    input  logic [$clog2(CAPACITY)-1:0] wdata,
    output logic [$clog2(CAPACITY)-1:0] slot
);

    localparam int SW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] written_reg;
    logic [CAPACITY-1:0] written_next;
    logic                hit_reg;
    logic                hit_next;
    logic [SW-1:0]       raddr_reg;
    logic [SW-1:0]       raddr_next;
    logic [SW-1:0]       ram_rdata;

    ple_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        written_next = written_reg;
        hit_next     = hit_reg;
        raddr_next   = raddr_reg;
        if (ctl.clear)
        begin
            written_next = '0;
        end
        else if (ctl.push)
        begin
            written_next[waddr] = 1'b1;
        end
        if (ctl.rd)
        begin
            hit_next   = written_reg[raddr];
            raddr_next = raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
            raddr_reg   <= '0;
        end
        else
        begin
            written_reg <= written_next;
            hit_reg     <= hit_next;
            raddr_reg   <= raddr_next;
        end
    end

    assign slot = hit_reg ? ram_rdata : raddr_reg;

endmodule

>>> rtl/core/ple_ctrl.sv
// Request sequencer: decodes each item, walks the link store, issues
// read-modify-write steps on the element, link and free-stack memories.
// Depends on ple_pkg and ple_stream_if.
module ple_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ple_stream_if.sink                    req,
    ple_stream_if.source                  rsp,
    output logic                          rd_en,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output logic                          elem_we,
    output logic [$clog2(CAPACITY)-1:0]   elem_waddr,
    output logic [ple_pkg::VALUE_W-1:0]   elem_wdata,
    input  logic [ple_pkg::VALUE_W-1:0]   elem_rdata,
    output logic                          link_we,
    output logic [$clog2(CAPACITY)-1:0]   link_waddr,
    output logic [$clog2(CAPACITY)-1:0]   link_wdata,
    input  logic [$clog2(CAPACITY)-1:0]   link_rdata,
    output ple_pkg::fs_ctl_t              fs_ctl,
    output logic [$clog2(CAPACITY)-1:0]   fs_raddr,
    output logic [$clog2(CAPACITY)-1:0]   fs_waddr,
    output logic [$clog2(CAPACITY)-1:0]   fs_wdata,
    input  logic [$clog2(CAPACITY)-1:0]   fs_slot
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = ple_pkg::COUNT_W;
    localparam int PW = ple_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_LINK,
        S_FIX,
        S_DFIRST,
        S_DISP,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        WK_INS,
        WK_DLAST,
        WK_DMID
    } walk_t;

    state_t                          state_reg, state_next;
    ple_pkg::op_t                    op_reg, op_next;
    logic [ple_pkg::VALUE_W-1:0]     value_reg, value_next;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic [SW-1:0]                   head_reg, head_next;
    logic [SW-1:0]                   tail_reg, tail_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [SW-1:0]                   slot_reg, slot_next;
    logic [SW-1:0]                   cur_reg, cur_next;
    logic [SW-1:0]                   prev_reg, prev_next;
    logic [CW-1:0]                   walk_cnt_reg, walk_cnt_next;
    logic                            walk_first_reg, walk_first_next;
    walk_t                           walk_kind_reg, walk_kind_next;
    ple_pkg::status_t                status_reg, status_next;
    logic [CW-1:0]                   remain_reg, remain_next;
    logic                            out_valid_reg, out_valid_next;
    ple_pkg::rsp_t                   out_data_reg, out_data_next;

    logic          out_free;
    logic          is_empty;
    logic          is_full;
    logic [CW:0]   count_p1;
    logic [CW-1:0] count_m1;
    logic          pos_ok_ins;
    logic          pos_ok_del;
    logic          ins_go;
    logic          ins_front;
    logic          dfirst_go;
    logic          dlast_go;
    logic [SW-1:0] walk_cur;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg >= CAP_C);
    assign count_p1   = {1'b0, count_reg} + (CW+1)'(1);
    assign count_m1   = count_reg - CW'(1);
    assign pos_ok_ins = (pos_reg != '0) && ({1'b0, pos_reg} <= count_p1);
    assign pos_ok_del = (pos_reg != '0) && (pos_reg <= count_reg);
    assign walk_cur   = walk_first_reg ? cur_reg : link_rdata;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        walk_cnt_next   = walk_cnt_reg;
        walk_first_next = walk_first_reg;
        walk_kind_next  = walk_kind_reg;
        status_next     = status_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;

        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        elem_we    = 1'b0;
        elem_waddr = fs_slot;
        elem_wdata = value_reg;
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        fs_ctl     = '0;
        fs_raddr   = is_full ? '0 : count_reg[SW-1:0];
        fs_waddr   = count_m1[SW-1:0];
        fs_wdata   = slot_reg;

        ins_go    = 1'b0;
        ins_front = 1'b0;
        dfirst_go = 1'b0;
        dlast_go  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.data.operation;
                    value_next = req.data.value;
                    pos_next   = req.data.position;
                    fs_ctl.rd  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next  = S_RESP;
                status_next = ple_pkg::ST_OK;
                case (op_reg)
                    ple_pkg::OP_INS_FIRST:
                    begin
                        ins_go    = 1'b1;
                        ins_front = 1'b1;
                    end
                    ple_pkg::OP_INS_LAST:
                    begin
                        ins_go = 1'b1;
                    end
                    ple_pkg::OP_INS_AT:
                    begin
                        if (!pos_ok_ins)
                        begin
                            status_next = ple_pkg::ST_BADPOS;
                        end
                        else if (pos_reg == PW'(1))
                        begin
                            ins_go    = 1'b1;
                            ins_front = 1'b1;
                        end
                        else if ({1'b0, pos_reg} == count_p1)
                        begin
                            ins_go = 1'b1;
                        end
                        else if (is_full)
                        begin
                            status_next = ple_pkg::ST_FULL;
                        end
                        else
                        begin
                            elem_we         = 1'b1;
                            slot_next       = fs_slot;
                            cur_next        = head_reg;
                            walk_first_next = 1'b1;
                            walk_cnt_next   = pos_reg - PW'(1);
                            walk_kind_next  = WK_INS;
                            state_next      = S_WALK;
                        end
                    end
                    ple_pkg::OP_DEL_FIRST:
                    begin
                        if (is_empty)
                        begin
                            status_next = ple_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            dfirst_go = 1'b1;
                        end
                    end
                    ple_pkg::OP_DEL_LAST:
                    begin
                        if (is_empty)
                        begin
                            status_next = ple_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            dlast_go = 1'b1;
                        end
                    end
                    ple_pkg::OP_DEL_AT:
                    begin
                        if (!pos_ok_del)
                        begin
                            status_next = ple_pkg::ST_BADPOS;
                        end
                        else if (pos_reg == PW'(1))
                        begin
                            dfirst_go = 1'b1;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            dlast_go = 1'b1;
                        end
                        else
                        begin
                            cur_next        = head_reg;
                            walk_first_next = 1'b1;
                            walk_cnt_next   = pos_reg - PW'(1);
                            walk_kind_next  = WK_DMID;
                            state_next      = S_WALK;
                        end
                    end
                    ple_pkg::OP_DISPLAY:
                    begin
                        if (is_empty)
                        begin
                            status_next = ple_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = head_reg;
                            remain_next = count_reg;
                            state_next  = S_DISP;
                        end
                    end
                    ple_pkg::OP_CLEAR:
                    begin
                        count_next   = '0;
                        head_next    = '0;
                        tail_next    = '0;
                        fs_ctl.clear = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase

                if (ins_go)
                begin
                    if (is_full)
                    begin
                        status_next = ple_pkg::ST_FULL;
                    end
                    else
                    begin
                        elem_we    = 1'b1;
                        link_we    = 1'b1;
                        link_waddr = fs_slot;
                        link_wdata = is_empty ? fs_slot : head_reg;
                        count_next = count_p1[CW-1:0];
                        slot_next  = fs_slot;
                        prev_next  = tail_reg;
                        if (is_empty)
                        begin
                            head_next = fs_slot;
                            tail_next = fs_slot;
                        end
                        else
                        begin
                            if (ins_front)
                            begin
                                head_next = fs_slot;
                            end
                            else
                            begin
                                tail_next = fs_slot;
                            end
                            state_next = S_LINK;
                        end
                    end
                end

                if (dfirst_go || dlast_go)
                begin
                    if (count_reg == CW'(1))
                    begin
                        fs_ctl.push = 1'b1;
                        fs_wdata    = head_reg;
                        count_next  = count_m1;
                        head_next   = '0;
                        tail_next   = '0;
                    end
                    else if (dfirst_go)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        slot_next  = head_reg;
                        state_next = S_DFIRST;
                    end
                    else
                    begin
                        cur_next        = head_reg;
                        walk_first_next = 1'b1;
                        walk_cnt_next   = count_m1;
                        walk_kind_next  = WK_DLAST;
                        state_next      = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (walk_cnt_reg != '0)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = walk_cur;
                    prev_next       = walk_cur;
                    walk_cnt_next   = walk_cnt_reg - CW'(1);
                    walk_first_next = 1'b0;
                end
                else
                begin
                    case (walk_kind_reg)
                        WK_INS:
                        begin
                            link_we    = 1'b1;
                            link_waddr = slot_reg;
                            link_wdata = walk_cur;
                            count_next = count_p1[CW-1:0];
                            state_next = S_LINK;
                        end
                        WK_DLAST:
                        begin
                            link_we     = 1'b1;
                            link_waddr  = prev_reg;
                            link_wdata  = head_reg;
                            tail_next   = prev_reg;
                            fs_ctl.push = 1'b1;
                            fs_wdata    = walk_cur;
                            count_next  = count_m1;
                            state_next  = S_RESP;
                        end
                        WK_DMID:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = walk_cur;
                            slot_next  = walk_cur;
                            state_next = S_FIX;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = slot_reg;
                state_next = S_RESP;
            end

            S_FIX:
            begin
                link_we     = 1'b1;
                link_waddr  = prev_reg;
                link_wdata  = link_rdata;
                fs_ctl.push = 1'b1;
                count_next  = count_m1;
                state_next  = S_RESP;
            end

            S_DFIRST:
            begin
                link_we     = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = link_rdata;
                head_next   = link_rdata;
                fs_ctl.push = 1'b1;
                count_next  = count_m1;
                state_next  = S_RESP;
            end

            S_DISP:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.status  = ple_pkg::ST_OK;
                    out_data_next.element = elem_rdata;
                    out_data_next.count   = count_reg;
                    out_data_next.last    = (remain_reg == CW'(1));
                    if (remain_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = link_rdata;
                        remain_next = remain_reg - CW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.status  = status_reg;
                    out_data_next.element = '0;
                    out_data_next.count   = count_reg;
                    out_data_next.last    = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= ple_pkg::OP_INS_FIRST;
            value_reg      <= '0;
            pos_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            slot_reg       <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            walk_cnt_reg   <= '0;
            walk_first_reg <= 1'b0;
            walk_kind_reg  <= WK_INS;
            status_reg     <= ple_pkg::ST_OK;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            value_reg      <= value_next;
            pos_reg        <= pos_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            slot_reg       <= slot_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            walk_cnt_reg   <= walk_cnt_next;
            walk_first_reg <= walk_first_next;
            walk_kind_reg  <= walk_kind_next;
            status_reg     <= status_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

>>> rtl/core/positional_list_engine.sv
// Positional list engine: circular singly linked list in element, link and
// free-stack RAMs, one request at a time, one link RAM read per walk cycle.
// Rejects, clear, and end ops that start or empty the list answer from
// dispatch; other end inserts and delete first add a link update state;
// insert/delete at walk to the position, delete last to the tail; display gives
// one item a cycle while rsp is ready. Async reset empties the list at once.
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    ple_stream_if.sink    req,
    ple_stream_if.source  rsp
);

    localparam int SW = $clog2(CAPACITY);

    logic                        rd_en;
    logic [SW-1:0]               rd_addr;
    logic                        elem_we;
    logic [SW-1:0]               elem_waddr;
    logic [ple_pkg::VALUE_W-1:0] elem_wdata;
    logic [ple_pkg::VALUE_W-1:0] elem_rdata;
    logic                        link_we;
    logic [SW-1:0]               link_waddr;
    logic [SW-1:0]               link_wdata;
    logic [SW-1:0]               link_rdata;
    ple_pkg::fs_ctl_t            fs_ctl;
    logic [SW-1:0]               fs_raddr;
    logic [SW-1:0]               fs_waddr;
    logic [SW-1:0]               fs_wdata;
    logic [SW-1:0]               fs_slot;

    ple_ram #(
        .WIDTH (ple_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (elem_rdata)
    );

    ple_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    ple_free_stack #(
        .CAPACITY (CAPACITY)
    ) u_free_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fs_ctl),
        .raddr (fs_raddr),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .slot  (fs_slot)
    );

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .elem_we    (elem_we),
        .elem_waddr (elem_waddr),
        .elem_wdata (elem_wdata),
        .elem_rdata (elem_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .fs_ctl     (fs_ctl),
        .fs_raddr   (fs_raddr),
        .fs_waddr   (fs_waddr),
        .fs_wdata   (fs_wdata),
        .fs_slot    (fs_slot)
    );

endmodule
